[hdl/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, constants and LED tables for the LED twinkle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

    // Field widths
    localparam int RANDOM_W   = 8;
    localparam int MV_W       = 13;
    localparam int PORT_W     = 2;
    localparam int PIN_W      = 3;
    localparam int PULSE_W    = 8;
    localparam int STOKE_W    = 7;
    localparam int MASK_W     = 7;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Table geometry
    localparam int TABLE_LENGTH = 16;
    localparam int TABLE_IDX_W  = $clog2(TABLE_LENGTH);

    // LED port codes
    typedef enum logic [PORT_W-1:0] {
        PORT_A    = 2'd0,
        PORT_B    = 2'd1,
        PORT_C    = 2'd2,
        PORT_NONE = 2'd3
    } pin_bank_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK_LIMIT_MASK     = 3'd0,
        CFG_SELF_TEST_ENABLE     = 3'd1,
        CFG_STAR_ENABLE          = 3'd2,
        CFG_RAIL_CHARGE_ENABLE   = 3'd3,
        CFG_HARVEST_BLINK_ENABLE = 3'd4,
        CFG_LOW_SUPPLY_MV        = 3'd5
    } cfg_index_t;

    // Pulse and stoker constants
    localparam logic [MASK_W-1:0]  HARSH_LIMIT      = 7'd7;
    localparam logic [MV_W-1:0]    STOKE_LOW_MV     = 13'd2300;
    localparam logic [STOKE_W-1:0] STOKE_LOW_TICKS  = 7'd72;
    localparam logic [MV_W-1:0]    STOKE_HIGH_MV    = 13'd2800;
    localparam logic [STOKE_W-1:0] STOKE_HIGH_TICKS = 7'd100;
    localparam logic [PULSE_W-1:0] SELF_TEST_TICKS  = 8'd100;
    localparam logic [PIN_W-1:0]   STAR_PIN         = 3'd4;
    localparam logic [PIN_W-1:0]   STOKE_PIN        = 3'd3;

    // Register reset values
    localparam logic [MASK_W-1:0] BLINK_LIMIT_MASK_RST = 7'd7;
    localparam logic [MV_W-1:0]   LOW_SUPPLY_MV_RST    = 13'd2500;

    typedef struct packed {
        pin_bank_t        port;
        logic [PIN_W-1:0] pin;
    } led_entry_t;

    // Normal twinkle order
    function automatic led_entry_t twinkle_lookup(input logic [TABLE_IDX_W-1:0] idx);
        led_entry_t e;
        case (idx)
            4'd0:    e = '{PORT_B,    3'd1};
            4'd1:    e = '{PORT_B,    3'd4};
            4'd2:    e = '{PORT_A,    3'd2};
            4'd3:    e = '{PORT_NONE, 3'd0};
            4'd4:    e = '{PORT_B,    3'd0};
            4'd5:    e = '{PORT_A,    3'd4};
            4'd6:    e = '{PORT_C,    3'd0};
            4'd7:    e = '{PORT_B,    3'd5};
            4'd8:    e = '{PORT_B,    3'd3};
            4'd9:    e = '{PORT_A,    3'd5};
            4'd10:   e = '{PORT_B,    3'd4};
            4'd11:   e = '{PORT_B,    3'd2};
            4'd12:   e = '{PORT_A,    3'd7};
            4'd13:   e = '{PORT_C,    3'd1};
            4'd14:   e = '{PORT_C,    3'd3};
            4'd15:   e = '{PORT_B,    3'd4};
            default: e = '{PORT_NONE, 3'd0};
        endcase
        return e;
    endfunction

    // Self-test walk order
    function automatic led_entry_t selftest_lookup(input logic [TABLE_IDX_W-1:0] idx);
        led_entry_t e;
        case (idx)
            4'd0:    e = '{PORT_C,    3'd3};
            4'd1:    e = '{PORT_B,    3'd4};
            4'd2:    e = '{PORT_C,    3'd0};
            4'd3:    e = '{PORT_A,    3'd4};
            4'd4:    e = '{PORT_A,    3'd5};
            4'd5:    e = '{PORT_A,    3'd7};
            4'd6:    e = '{PORT_A,    3'd2};
            4'd7:    e = '{PORT_B,    3'd5};
            4'd8:    e = '{PORT_B,    3'd3};
            4'd9:    e = '{PORT_B,    3'd1};
            4'd10:   e = '{PORT_B,    3'd0};
            4'd11:   e = '{PORT_B,    3'd2};
            4'd12:   e = '{PORT_C,    3'd3};
            4'd13:   e = '{PORT_C,    3'd1};
            default: e = '{PORT_NONE, 3'd0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[hdl/led_twinkle_sequencer.sv]
// ----------------------------------------------------------------------------
// led_twinkle_sequencer
// Picks one LED per twinkle tick and reports pulse length, stoker pulse
// and reseed request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one tick item: random_byte,
//   in_startup, supply_mv. Output channel (out_valid / out_stall) carries one
//   result item per tick: led_port, led_pin, pulse_ticks, stoker_hold,
//   stoker_ticks, reseed_request.
//   Two register stages: an input register and a result register, with the
//   table lookup, pulse mask and voltage compares between them. An item
//   passes the input register, then the result register; throughput is
//   one item per cycle unless stalled, set by the single compute stage.
//   When the receiver stalls, the result register holds, the input register
//   fills behind it and in_stall rises only once both are occupied.
//   Reset clears both valid flags, the step counter and all configuration
//   registers to their defaults. Configuration is written through cfg_we /
//   cfg_index / cfg_data; writes to unlisted indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module led_twinkle_sequencer
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0]  cfg_data,

    // tick input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [lts_pkg::RANDOM_W-1:0]    random_byte,
    input  wire logic                            in_startup,
    input  wire logic [lts_pkg::MV_W-1:0]        supply_mv,

    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [lts_pkg::PORT_W-1:0]           led_port,
    output logic [lts_pkg::PIN_W-1:0]            led_pin,
    output logic [lts_pkg::PULSE_W-1:0]          pulse_ticks,
    output logic                                 stoker_hold,
    output logic [lts_pkg::STOKE_W-1:0]          stoker_ticks,
    output logic                                 reseed_request
);

    import lts_pkg::*;

    // Configuration registers
    logic [MASK_W-1:0] blink_limit_mask_reg;
    logic              self_test_enable_reg;
    logic              star_enable_reg;
    logic              rail_charge_enable_reg;
    logic              harvest_blink_enable_reg;
    logic [MV_W-1:0]   low_supply_mv_reg;

    // Input stage
    logic                in_valid_reg;
    logic [RANDOM_W-1:0] random_reg;
    logic                startup_reg;
    logic [MV_W-1:0]     mv_reg;

    // Step counter
    logic [COUNT_W-1:0] step_counter_reg;
    logic [COUNT_W-1:0] step_counter_next;

    // Result stage
    logic               out_valid_reg;
    pin_bank_t          port_reg;
    logic [PIN_W-1:0]   pin_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic               hold_reg;
    logic [STOKE_W-1:0] stoke_reg;
    logic               reseed_reg;

    // Computed result
    pin_bank_t          port_next;
    logic [PIN_W-1:0]   pin_next;
    logic [PULSE_W-1:0] pulse_next;
    logic               hold_next;
    logic [STOKE_W-1:0] stoke_next;
    logic               reseed_next;

    logic out_load;
    logic in_load;

    // Handshake: result register loads when empty or being taken
    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_limit_mask_reg     <= BLINK_LIMIT_MASK_RST;
            self_test_enable_reg     <= 1'b0;
            star_enable_reg          <= 1'b1;
            rail_charge_enable_reg   <= 1'b1;
            harvest_blink_enable_reg <= 1'b1;
            low_supply_mv_reg        <= LOW_SUPPLY_MV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLINK_LIMIT_MASK:     blink_limit_mask_reg     <= cfg_data[MASK_W-1:0];
                CFG_SELF_TEST_ENABLE:     self_test_enable_reg     <= cfg_data[0];
                CFG_STAR_ENABLE:          star_enable_reg          <= cfg_data[0];
                CFG_RAIL_CHARGE_ENABLE:   rail_charge_enable_reg   <= cfg_data[0];
                CFG_HARVEST_BLINK_ENABLE: harvest_blink_enable_reg <= cfg_data[0];
                CFG_LOW_SUPPLY_MV:        low_supply_mv_reg        <= cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            random_reg  <= random_byte;
            startup_reg <= in_startup;
            mv_reg      <= supply_mv;
        end
    end

    // Tick computation
    always_comb
    begin
        logic [MASK_W-1:0]      limit;
        logic [MASK_W-1:0]      gray;
        logic [TABLE_IDX_W-1:0] idx;
        led_entry_t             e;
        logic                   lit;

        // pulse length from masked random value
        limit = blink_limit_mask_reg;
        if ((startup_reg || (mv_reg < low_supply_mv_reg)) && (limit > HARSH_LIMIT))
        begin
            limit = HARSH_LIMIT;
        end
        gray       = random_reg[MASK_W-1:0] ^ random_reg[MASK_W:1];
        pulse_next = {1'b0, gray & limit} + PULSE_W'(1);
        hold_next  = 1'b0;

        // table lookup
        idx = random_reg[TABLE_IDX_W-1:0] + step_counter_reg[TABLE_IDX_W-1:0];
        if (self_test_enable_reg)
        begin
            pulse_next = SELF_TEST_TICKS;
            hold_next  = 1'b1;
            e          = selftest_lookup(step_counter_reg[TABLE_IDX_W-1:0]);
        end
        else
        begin
            e = twinkle_lookup(idx);
        end
        port_next  = e.port;
        pin_next   = e.pin;
        stoke_next = '0;
        lit        = 1'b0;

        // gating per port
        case (e.port)
            PORT_A:
            begin
                lit = 1'b1;
            end
            PORT_B:
            begin
                lit = (e.pin != STAR_PIN) || star_enable_reg || self_test_enable_reg;
            end
            PORT_C:
            begin
                if ((e.pin == STOKE_PIN) && rail_charge_enable_reg)
                begin
                    if (mv_reg >= STOKE_HIGH_MV)
                    begin
                        stoke_next = STOKE_HIGH_TICKS;
                    end
                    else if (mv_reg >= STOKE_LOW_MV)
                    begin
                        stoke_next = STOKE_LOW_TICKS;
                    end
                end
                else
                begin
                    lit = harvest_blink_enable_reg;
                end
            end
            default:
            begin
                lit = 1'b0;
            end
        endcase

        if (!lit)
        begin
            port_next  = PORT_NONE;
            pin_next   = '0;
            pulse_next = '0;
        end

        // counter advance and reseed
        step_counter_next = step_counter_reg + COUNT_W'(1);
        reseed_next       = (step_counter_next == {COUNT_W{1'b1}});
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_counter_reg <= '0;
        end
        else if (out_load)
        begin
            step_counter_reg <= step_counter_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            port_reg   <= port_next;
            pin_reg    <= pin_next;
            pulse_reg  <= pulse_next;
            hold_reg   <= hold_next;
            stoke_reg  <= stoke_next;
            reseed_reg <= reseed_next;
        end
    end

    // Outputs
    assign out_valid      = out_valid_reg;
    assign led_port       = port_reg;
    assign led_pin        = pin_reg;
    assign pulse_ticks    = pulse_reg;
    assign stoker_hold    = hold_reg;
    assign stoker_ticks   = stoke_reg;
    assign reseed_request = reseed_reg;

endmodule

`default_nettype wire

[tb/sv/led_twinkle_checker.sv]
// ----------------------------------------------------------------------------
// led_twinkle_checker
// Watches the tick and result channels of the LED twinkle sequencer. It keeps
// its own copy of the step counter and the registers, works out the LED,
// pulse and stoker outcome of every accepted tick and checks each result
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module led_twinkle_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [lts_pkg::RANDOM_W-1:0]     random_byte,
    input  logic                             in_startup,
    input  logic [lts_pkg::MV_W-1:0]         supply_mv,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [lts_pkg::PORT_W-1:0]       led_port,
    input  logic [lts_pkg::PIN_W-1:0]        led_pin,
    input  logic [lts_pkg::PULSE_W-1:0]      pulse_ticks,
    input  logic                             stoker_hold,
    input  logic [lts_pkg::STOKE_W-1:0]      stoker_ticks,
    input  logic                             reseed_request,
    output int                               fail_count,
    output int                               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    typedef struct packed {
        pin_bank_t            port;
        logic [PIN_W-1:0]     pin;
        logic [PULSE_W-1:0]   pulse;
        logic                 hold;
        logic [STOKE_W-1:0]   stoke;
        logic                 reseed;
    } tick_outcome_t;

    // {port, pin} per table slot, slot 0 leftmost
    localparam logic [0:TABLE_LENGTH-1][PORT_W+PIN_W-1:0] TWINKLE_ORDER = {
        {PORT_B, 3'd1}, {PORT_B, 3'd4}, {PORT_A, 3'd2}, {PORT_NONE, 3'd0},
        {PORT_B, 3'd0}, {PORT_A, 3'd4}, {PORT_C, 3'd0}, {PORT_B, 3'd5},
        {PORT_B, 3'd3}, {PORT_A, 3'd5}, {PORT_B, 3'd4}, {PORT_B, 3'd2},
        {PORT_A, 3'd7}, {PORT_C, 3'd1}, {PORT_C, 3'd3}, {PORT_B, 3'd4}
    };
    localparam logic [0:TABLE_LENGTH-1][PORT_W+PIN_W-1:0] WALK_ORDER = {
        {PORT_C, 3'd3}, {PORT_B, 3'd4}, {PORT_C, 3'd0}, {PORT_A, 3'd4},
        {PORT_A, 3'd5}, {PORT_A, 3'd7}, {PORT_A, 3'd2}, {PORT_B, 3'd5},
        {PORT_B, 3'd3}, {PORT_B, 3'd1}, {PORT_B, 3'd0}, {PORT_B, 3'd2},
        {PORT_C, 3'd3}, {PORT_C, 3'd1}, {PORT_NONE, 3'd0}, {PORT_NONE, 3'd0}
    };

    // shadow registers and step counter
    logic [MASK_W-1:0]   limit_mask;
    logic                self_test_on;
    logic                star_on;
    logic                rail_on;
    logic                harvest_on;
    logic [MV_W-1:0]     low_mv;
    logic [COUNT_W-1:0]  step_count;

    tick_outcome_t       expected_ticks[$];
    tick_outcome_t       want;

    function automatic tick_outcome_t predict_tick(input logic [RANDOM_W-1:0] rnd,
                                                   input logic startup,
                                                   input logic [MV_W-1:0] mv);
        logic [MASK_W-1:0]            limit;
        logic [TABLE_IDX_W-1:0]       slot;
        logic [PORT_W+PIN_W-1:0]      entry;
        logic                         lit;
        tick_outcome_t                r;
        limit = limit_mask;
        if ((startup || mv < low_mv) && limit > HARSH_LIMIT)
            limit = HARSH_LIMIT;
        // gray-coded random byte, masked, plus one
        r.pulse = {1'b0, (rnd[6:0] ^ rnd[7:1]) & limit} + 8'd1;
        r.hold  = self_test_on;
        r.stoke = '0;
        if (self_test_on)
        begin
            r.pulse = SELF_TEST_TICKS;
            slot    = step_count[TABLE_IDX_W-1:0];
            entry   = WALK_ORDER[slot];
        end
        else
        begin
            slot  = rnd[TABLE_IDX_W-1:0] + step_count[TABLE_IDX_W-1:0];
            entry = TWINKLE_ORDER[slot];
        end
        r.port = pin_bank_t'(entry[PORT_W+PIN_W-1:PIN_W]);
        r.pin  = entry[PIN_W-1:0];
        lit    = 1'b0;
        case (r.port)
            PORT_A: lit = 1'b1;
            PORT_B: lit = (r.pin != STAR_PIN) || star_on || self_test_on;
            PORT_C:
            begin
                // stoke slot only charges the rail when rail charging is on
                if (r.pin == STOKE_PIN && rail_on)
                begin
                    if (mv >= STOKE_HIGH_MV)
                        r.stoke = STOKE_HIGH_TICKS;
                    else if (mv >= STOKE_LOW_MV)
                        r.stoke = STOKE_LOW_TICKS;
                end
                else
                    lit = harvest_on;
            end
            default: lit = 1'b0;
        endcase
        // counter is about to become 255
        r.reseed = (step_count == 8'd254);
        if (!lit)
        begin
            r.port  = PORT_NONE;
            r.pin   = '0;
            r.pulse = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
    endtask

    // sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_mask   = BLINK_LIMIT_MASK_RST;
            self_test_on = 1'b0;
            star_on      = 1'b1;
            rail_on      = 1'b1;
            harvest_on   = 1'b1;
            low_mv       = LOW_SUPPLY_MV_RST;
            step_count   = '0;
            expected_ticks.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BLINK_LIMIT_MASK:     limit_mask   = cfg_data[MASK_W-1:0];
                    CFG_SELF_TEST_ENABLE:     self_test_on = cfg_data[0];
                    CFG_STAR_ENABLE:          star_on      = cfg_data[0];
                    CFG_RAIL_CHARGE_ENABLE:   rail_on      = cfg_data[0];
                    CFG_HARVEST_BLINK_ENABLE: harvest_on   = cfg_data[0];
                    CFG_LOW_SUPPLY_MV:        low_mv       = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_ticks.push_back(predict_tick(random_byte, in_startup, supply_mv));
                step_count = step_count + 8'd1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                    report_mismatch("result item with no tick outstanding");
                else
                begin
                    want = expected_ticks.pop_front();
                    compare_field("led_port", led_port, want.port);
                    compare_field("led_pin", led_pin, want.pin);
                    compare_field("pulse_ticks", pulse_ticks, want.pulse);
                    compare_field("stoker_hold", stoker_hold, want.hold);
                    compare_field("stoker_ticks", stoker_ticks, want.stoke);
                    compare_field("reseed_request", reseed_request, want.reseed);
                end
            end
        end
        pending_results = expected_ticks.size();
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Top of the LED twinkle sequencer bench. Drives directed edge ticks, then
// random ticks across several register settings (self-test, gating off,
// extreme masks and thresholds) under random sender gaps and receiver stalls.
// A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int TICKS_PER_SET = 185;
    localparam int NUM_SETS      = 7;
    // indexes past the register map, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [RANDOM_W-1:0]     random_byte = '0;
    logic                    in_startup = 1'b0;
    logic [MV_W-1:0]         supply_mv = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [PORT_W-1:0]       led_port;
    logic [PIN_W-1:0]        led_pin;
    logic [PULSE_W-1:0]      pulse_ticks;
    logic                    stoker_hold;
    logic [STOKE_W-1:0]      stoker_ticks;
    logic                    reseed_request;
    int                      fail_count;
    int                      pending_results;

    int                      send_idle_pct = 25;
    int                      recv_idle_pct = 50;
    int                      cycle_count = 0;

    led_twinkle_sequencer dut (.*);
    led_twinkle_checker   u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one tick item, with random gaps in front of it
    task automatic send_tick(input logic [RANDOM_W-1:0] rnd, input logic startup,
                             input logic [MV_W-1:0] mv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        random_byte <= rnd;
        in_startup  <= startup;
        supply_mv   <= mv;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0]  mask_w, test_w, star_w, rail_w, harv_w, low_w;
        logic [RANDOM_W-1:0]    rnd;
        logic                   startup;
        int                     mv;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and voltage thresholds at reset settings
        send_tick(8'h00, 1'b0, 13'd0);
        send_tick(8'hFF, 1'b1, 13'd8191);
        send_tick(8'hFF, 1'b0, 13'd8191);
        send_tick(8'hAA, 1'b0, 13'd2299);
        send_tick(8'h55, 1'b0, 13'd2300);
        send_tick(8'h7F, 1'b0, 13'd2799);
        send_tick(8'h80, 1'b0, 13'd2800);
        send_tick(8'hFE, 1'b0, 13'd2499);
        send_tick(8'hFE, 1'b0, 13'd2500);
        send_tick(8'h01, 1'b1, 13'd2500);
        // constant byte walks slots 10..15 and 0..3: star, stoke, idle entry
        repeat (10) send_tick(8'h00, 1'b0, 13'd3000);

        for (int set = 0; set < NUM_SETS; set++)
        begin
            wait_for_drain();
            case (set)
                0: begin mask_w = 7;   test_w = 0; star_w = 1; rail_w = 1; harv_w = 1; low_w = 2500; end
                1: begin mask_w = 127; test_w = 0; star_w = 0; rail_w = 0; harv_w = 1; low_w = 0;    end
                2: begin mask_w = 0;   test_w = 1; star_w = 0; rail_w = 1; harv_w = 0; low_w = 8191; end
                3: begin mask_w = 63;  test_w = 0; star_w = 1; rail_w = 1; harv_w = 0; low_w = 8191; end
                4: begin mask_w = 127; test_w = 0; star_w = 0; rail_w = 0; harv_w = 0; low_w = 2500; end
                5: begin mask_w = 31;  test_w = 1; star_w = 1; rail_w = 0; harv_w = 1; low_w = 4000; end
                default:
                begin
                    // full-width data, only the low bits should land
                    mask_w = CFG_DATA_W'($urandom_range(8191));
                    test_w = CFG_DATA_W'($urandom_range(8191));
                    star_w = CFG_DATA_W'($urandom_range(8191));
                    rail_w = CFG_DATA_W'($urandom_range(8191));
                    harv_w = CFG_DATA_W'($urandom_range(8191));
                    low_w  = CFG_DATA_W'($urandom_range(8191));
                end
            endcase
            write_reg(CFG_BLINK_LIMIT_MASK, mask_w);
            write_reg(CFG_SELF_TEST_ENABLE, test_w);
            write_reg(CFG_STAR_ENABLE, star_w);
            write_reg(CFG_RAIL_CHARGE_ENABLE, rail_w);
            write_reg(CFG_HARVEST_BLINK_ENABLE, harv_w);
            write_reg(CFG_LOW_SUPPLY_MV, low_w);
            if (set == 0)
            begin
                write_reg(CFG_SPARE_LO, '1);
                write_reg(CFG_SPARE_HI, '1);
            end

            // sender/receiver idle schedule
            if (set < 3)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 50;
            end
            else if (set < 5)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < TICKS_PER_SET; n++)
            begin
                rnd     = RANDOM_W'($urandom_range(255));
                startup = ($urandom_range(4) == 0);
                // supply: uniform, or hugging one of the three thresholds
                case ($urandom_range(3))
                    0: mv = $urandom_range(8191);
                    1: mv = int'(STOKE_LOW_MV) - 2 + int'($urandom_range(4));
                    2: mv = int'(STOKE_HIGH_MV) - 2 + int'($urandom_range(4));
                    default: mv = int'(low_w) - 2 + int'($urandom_range(4));
                endcase
                if (mv < 0)
                    mv = 0;
                if (mv > 8191)
                    mv = 8191;
                send_tick(rnd, startup, mv[MV_W-1:0]);
                if ($urandom_range(99) == 0)
                    wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
